### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the median filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define TACMF_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TACMF_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

### sv/tacmf_pkg.sv
// ----------------------------------------------------------------------------
// tacmf_pkg
// Constants and register codes shared by the three-axis median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tacmf_pkg;

    localparam int AXES             = 3;
    localparam int WINDOW_LEN_DEF   = 10;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Clamp limit register: unsigned, 10 fractional bits, reset is 16.0.
    localparam int                 CLAMP_W     = 15;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd16384;

    // Window presets, decimal values times 1024 rounded to nearest.
    localparam int PRESET_X = -9626;
    localparam int PRESET_Y = -461;
    localparam int PRESET_Z = 614;

    // Configuration port geometry: 32-bit registers on word addresses.
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CLAMP_LIMIT = 1'b0;

endpackage

`default_nettype wire

### sv/tacmf_lane.sv
// ----------------------------------------------------------------------------
// tacmf_lane
// One axis: clamps the sample, shifts it into the window and picks the
// lower median of the window by ranking every entry against all others.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tacmf_lane
    import tacmf_pkg::*;
#(
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int PRESET       = 0
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift_en,
    input  wire logic        [CLAMP_W-1:0]      clamp_limit,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed      [SAMPLE_WIDTH-1:0] median
);

    localparam int CMP_W    = ((SAMPLE_WIDTH > CLAMP_W) ? SAMPLE_WIDTH : CLAMP_W) + 1;
    localparam int RANK_W   = $clog2(WINDOW_LEN);
    localparam int MED_RANK = WINDOW_LEN - 1 - WINDOW_LEN / 2;

    logic signed [SAMPLE_WIDTH-1:0] win_reg  [WINDOW_LEN];
    logic signed [SAMPLE_WIDTH-1:0] win_next [WINDOW_LEN];

    logic signed [CMP_W-1:0]        sample_ext;
    logic signed [CMP_W-1:0]        lim_pos;
    logic signed [CMP_W-1:0]        lim_neg;
    logic signed [CMP_W-1:0]        clamped;

    logic        [RANK_W-1:0]       rank [WINDOW_LEN];
    logic        [WINDOW_LEN-1:0]   sel;

    // Clamp in a width that holds both the sample and the negated limit.
    always_comb
    begin
        sample_ext = CMP_W'(sample);
        lim_pos    = signed'({{(CMP_W - CLAMP_W){1'b0}}, clamp_limit});
        lim_neg    = -lim_pos;
        if (sample_ext > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sample_ext < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sample_ext;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WINDOW_LEN-1] = clamped[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= SAMPLE_WIDTH'(PRESET);
            end
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    // Rank of an entry is the number of entries below it; equal values are
    // ordered by position, so the ranks always form a permutation.
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((win_reg[j] < win_reg[i]) || ((win_reg[j] == win_reg[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
            sel[i] = (rank[i] == RANK_W'(MED_RANK));
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (sel[i])
            begin
                median = median | win_reg[i];
            end
        end
    end

    `TACMF_ASSERT(a_median_sel_onehot, clk, rst_n, $onehot(sel), "median select not one-hot")

endmodule

`default_nettype wire

### sv/tacmf_merge.sv
// ----------------------------------------------------------------------------
// tacmf_merge
// Gathers the three lane medians into one result item and holds it in an
// output register, so a new item can enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tacmf_merge
    import tacmf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0] lane_med [AXES],
    input  wire logic                           out_stall,
    output logic                                in_stall,
    output logic                                out_valid,
    output logic signed      [SAMPLE_WIDTH-1:0] med_out [AXES]
);

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] med_reg [AXES];
    logic                           advance;

    // The windows hold the item in flight until its medians move on.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            med_reg <= lane_med;
        end
    end

    assign out_valid = out_valid_reg;
    assign med_out   = med_reg;

    `TACMF_ASSERT(a_accept_fills_stage, clk, rst_n, accept |=> s1_valid_reg, "accepted item lost")
    `TACMF_ASSERT(a_advance_loads_out, clk, rst_n, advance |=> out_valid_reg, "result not registered")
    `TACMF_ASSERT_ALWAYS(a_stall_only_when_full, clk, in_stall |-> s1_valid_reg, "stall while empty")

endmodule

`default_nettype wire

### sv/three_axis_clamped_median_filter_top.sv
// An accepted item shifts into the windows; its medians load the output register once
// that register is free. Throughput: one item per cycle while the output is not stalled;
// the rank compare across all window entries of each axis lane is combinational.
// Reset: windows load their presets (x -9.4, y -0.45, z 0.6), the clamp limit
// returns to 16.0 and no item is in flight.
// ----------------------------------------------------------------------------
// three_axis_clamped_median_filter_top
// Three-axis clamped sliding-window median filter with an APB-style register.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_clamped_median_filter_top
    import tacmf_pkg::*;
#(
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic        [PADDR_W-1:0]      paddr,
    input  wire logic        [PDATA_W-1:0]      pwdata,
    output logic             [PDATA_W-1:0]      prdata,
    output logic                                pready,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed      [SAMPLE_WIDTH-1:0] median_x,
    output logic signed      [SAMPLE_WIDTH-1:0] median_y,
    output logic signed      [SAMPLE_WIDTH-1:0] median_z
);

    logic        [CLAMP_W-1:0]      clamp_limit_reg;
    logic        [CLAMP_W-1:0]      clamp_limit_next;
    logic        [REG_IDX_W-1:0]    reg_idx;
    logic                           wr_en;
    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] lane_med [AXES];
    logic signed [SAMPLE_WIDTH-1:0] med_out  [AXES];

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        clamp_limit_next = clamp_limit_reg;
        if (wr_en && (reg_idx == REG_CLAMP_LIMIT))
        begin
            clamp_limit_next = pwdata[CLAMP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_CLAMP_LIMIT)
        begin
            prdata = PDATA_W'(clamp_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_limit_reg <= CLAMP_RESET;
        end
        else
        begin
            clamp_limit_reg <= clamp_limit_next;
        end
    end

    assign accept = in_valid && !in_stall;

    tacmf_lane #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PRESET       (PRESET_X)
    ) u_lane_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (accept),
        .clamp_limit (clamp_limit_reg),
        .sample      (accel_x),
        .median      (lane_med[0])
    );

    tacmf_lane #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PRESET       (PRESET_Y)
    ) u_lane_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (accept),
        .clamp_limit (clamp_limit_reg),
        .sample      (accel_y),
        .median      (lane_med[1])
    );

    tacmf_lane #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PRESET       (PRESET_Z)
    ) u_lane_z (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (accept),
        .clamp_limit (clamp_limit_reg),
        .sample      (accel_z),
        .median      (lane_med[2])
    );

    tacmf_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .lane_med  (lane_med),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .med_out   (med_out)
    );

    assign median_x = med_out[0];
    assign median_y = med_out[1];
    assign median_z = med_out[2];

endmodule

`default_nettype wire
